FILE: sv/c2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types and constants of the convolution layer engine.
// ----------------------------------------------------------------------------
package c2d_pkg;

  // Item kinds carried in the input tuser
  localparam logic [1:0] KIND_LOAD_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_LOAD_WEIGHT = 2'd1;
  localparam logic [1:0] KIND_LOAD_BIAS   = 2'd2;
  localparam logic [1:0] KIND_COMPUTE     = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_SAT = 2'd1;
  localparam logic [1:0] STAT_OOM = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_IN_WIDTH    = 3'd0;
  localparam logic [2:0] REG_IN_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_IN_DEPTH    = 3'd2;
  localparam logic [2:0] REG_KERNEL_SIZE = 3'd3;
  localparam logic [2:0] REG_NUM_FILTERS = 3'd4;
  localparam logic [2:0] REG_STRIDE      = 3'd5;
  localparam logic [2:0] REG_PADDING     = 3'd6;

  // Width of a clamped size value (all size limits stay at or below 256)
  localparam int SZW = 9;
  // Signed width of a window coordinate
  localparam int CW = 10;
  // Signed width of the padded span
  localparam int SPW = SZW + 2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_S1,
    ST_S2,
    ST_S3,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } state_t;

endpackage

FILE: sv/conv2d_layer_forward.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_layer_forward
// Convolution layer engine: loads samples, weights and biases, and computes
// one output position per compute item with stride and zero padding.
// ----------------------------------------------------------------------------
// Load items are accepted whenever the engine is idle. A compute item runs a
// short divide loop that finds the output map size, the setup states ST_S1,
// ST_S2 and ST_S3 for the address bases, and then the tap loop, which runs one
// multiply-accumulate a cycle through the sample and weight memories. Taps that
// fall in the padding are still stepped through, with a zero product.
// After reset the weight memory is swept to zero, one entry a cycle, over all
// MAX_KERNEL^2*MAX_DEPTH*MAX_FILTERS entries (6400 by default); no item is
// taken during the sweep, while configuration writes are. Loads go on while
// a result waits on the output.
module conv2d_layer_forward #(
  parameter int MAX_WIDTH   = 32,
  parameter int MAX_HEIGHT  = 32,
  parameter int MAX_DEPTH   = 16,
  parameter int MAX_KERNEL  = 5,
  parameter int MAX_FILTERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // [13:0] load_address, [29:14] sample_value, [61:30] bias_value,
  // [65:62] out_filter, [70:66] out_row, [75:71] out_col, [79:76] zero
  input  logic [79:0] in_tdata,
  // [1:0] kind
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] result_value, [45:32] result_index, [47:46] zero
  output logic [47:0] out_tdata,
  // [1:0] status
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  import c2d_pkg::*;

  localparam int IN_SIZE = MAX_WIDTH * MAX_HEIGHT * MAX_DEPTH;
  localparam int W_SIZE  = MAX_KERNEL * MAX_KERNEL * MAX_DEPTH * MAX_FILTERS;
  localparam int IAW     = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
  localparam int WAW     = (W_SIZE > 1) ? $clog2(W_SIZE) : 1;
  localparam int FAW     = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int XW      = IAW + 12;
  localparam int TAPS    = MAX_KERNEL * MAX_KERNEL * MAX_DEPTH;
  localparam int ACW     = 34 + $clog2(TAPS + 1);

  // Input item fields
  logic [1:0]         kind;
  logic [13:0]        load_address;
  logic [15:0]        sample_value;
  logic [31:0]        bias_value;
  logic [3:0]         out_filter;
  logic [4:0]         out_row;
  logic [4:0]         out_col;

  assign kind         = in_tuser[1:0];
  assign load_address = in_tdata[13:0];
  assign sample_value = in_tdata[29:14];
  assign bias_value   = in_tdata[61:30];
  assign out_filter   = in_tdata[65:62];
  assign out_row      = in_tdata[70:66];
  assign out_col      = in_tdata[75:71];

  state_t state_r, state_nxt;

  // Configuration registers
  logic [5:0] width_r, height_r;
  logic [4:0] depth_r, filters_r;
  logic [2:0] kernel_r, stride_r, padding_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= 6'd32;
      height_r  <= 6'd32;
      depth_r   <= 5'd3;
      kernel_r  <= 3'd3;
      filters_r <= 5'd1;
      stride_r  <= 3'd1;
      padding_r <= 3'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IN_WIDTH:    width_r   <= cfg_data;
        REG_IN_HEIGHT:   height_r  <= cfg_data;
        REG_IN_DEPTH:    depth_r   <= cfg_data[4:0];
        REG_KERNEL_SIZE: kernel_r  <= cfg_data[2:0];
        REG_NUM_FILTERS: filters_r <= cfg_data[4:0];
        REG_STRIDE:      stride_r  <= cfg_data[2:0];
        REG_PADDING:     padding_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Sizes saturated to their ranges
  function automatic logic [SZW-1:0] clamp_sz(input logic [5:0] v, input int hi);
    logic [SZW-1:0] res;
    if (v == 6'd0) begin
      res = SZW'(1);
    end else if (32'(v) > hi) begin
      res = SZW'(hi);
    end else begin
      res = SZW'(v);
    end
    return res;
  endfunction

  logic [SZW-1:0] w_c, h_c, d_c, k_c, m_c;
  logic [2:0]     s_c, p_c;

  assign w_c = clamp_sz(width_r, MAX_WIDTH);
  assign h_c = clamp_sz(height_r, MAX_HEIGHT);
  assign d_c = clamp_sz({1'b0, depth_r}, MAX_DEPTH);
  assign k_c = clamp_sz({3'b0, kernel_r}, MAX_KERNEL);
  assign m_c = clamp_sz({1'b0, filters_r}, MAX_FILTERS);
  assign s_c = (stride_r == 3'd0) ? 3'd1 : ((stride_r > 3'd4) ? 3'd4 : stride_r);
  assign p_c = (padding_r > 3'd4) ? 3'd4 : padding_r;

  logic signed [SPW-1:0] span_w, span_h;
  assign span_w = $signed(SPW'(w_c)) - $signed(SPW'(k_c)) + $signed(SPW'({p_c, 1'b0}));
  assign span_h = $signed(SPW'(h_c)) - $signed(SPW'(k_c)) + $signed(SPW'({p_c, 1'b0}));

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // Weight memory write side, shared with the clearing sweep
  logic [WAW:0]   clr_cnt_r;
  logic           clr_last;
  logic           w_we;
  logic [WAW-1:0] w_waddr;
  logic [15:0]    w_wdata;
  logic [WAW-1:0] widx_r;
  logic [15:0]    w_rdata;

  assign clr_last = (clr_cnt_r == (WAW + 1)'(W_SIZE - 1));

  always_comb begin
    if (state_r == ST_CLEAR) begin
      w_we    = 1'b1;
      w_waddr = clr_cnt_r[WAW-1:0];
      w_wdata = '0;
    end else begin
      w_we    = in_acc && (kind == KIND_LOAD_WEIGHT) && (32'(load_address) < W_SIZE);
      w_waddr = WAW'(load_address);
      w_wdata = sample_value;
    end
  end

  c2d_ram #(.WIDTH(16), .DEPTH(W_SIZE)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (widx_r),
    .rdata (w_rdata)
  );

  // Sample memory
  logic                 x_we;
  logic signed [XW-1:0] plane_r, rowoff_r;
  logic signed [CW-1:0] y_r, x_r;
  logic signed [XW-1:0] x_addr_full;
  logic [15:0]          x_rdata;

  assign x_we        = in_acc && (kind == KIND_LOAD_SAMPLE) && (32'(load_address) < IN_SIZE);
  assign x_addr_full = plane_r + rowoff_r + XW'(x_r);

  c2d_ram #(.WIDTH(16), .DEPTH(IN_SIZE)) u_sample_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (IAW'(load_address)),
    .wdata (sample_value),
    .raddr (x_addr_full[IAW-1:0]),
    .rdata (x_rdata)
  );

  // Bias registers
  logic [31:0] bias_r [MAX_FILTERS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_FILTERS; i++) begin
        bias_r[i] <= '0;
      end
    end else if (in_acc && (kind == KIND_LOAD_BIAS) && (32'(load_address) < MAX_FILTERS)) begin
      bias_r[FAW'(load_address)] <= bias_value;
    end
  end

  // Compute item context and loop state
  logic [3:0]            f_r;
  logic [4:0]            row_r, col_r;
  logic signed [SPW-1:0] rw_r, rh_r;
  logic [SZW-1:0]        qw_r, qh_r, ow_r, oh_r;
  logic                  negw_r, negh_r, oom_r;
  logic [2*SZW-1:0]      kk_r;
  logic [3*SZW-1:0]      dk_r;
  logic [13:0]           foh_r, idx1_r, idx_r;
  logic signed [CW-1:0]  y0_r, x0_r;
  logic signed [XW-1:0]  y0w_r, hw_r;
  logic [SZW-1:0]        c_r, fy_r, fx_r;
  logic signed [ACW-1:0] acc_r;

  logic p1_v_r, p1_ok_r, p2_v_r;
  logic signed [31:0] prod_r;

  logic done_w, done_h, tap_ok, last_tap, fx_end, fy_end;
  logic [SZW-1:0] ow_v, oh_v;

  assign done_w = negw_r || (rw_r < $signed(SPW'(s_c)));
  assign done_h = negh_r || (rh_r < $signed(SPW'(s_c)));
  assign ow_v   = negw_r ? '0 : qw_r + SZW'(1);
  assign oh_v   = negh_r ? '0 : qh_r + SZW'(1);

  assign tap_ok   = (y_r >= 0) && (y_r < $signed(CW'(h_c))) &&
                    (x_r >= 0) && (x_r < $signed(CW'(w_c)));
  assign fx_end   = (fx_r == k_c - SZW'(1));
  assign fy_end   = (fy_r == k_c - SZW'(1));
  assign last_tap = fx_end && fy_end && (c_r == d_c - SZW'(1));

  // Final sum and saturation
  logic signed [ACW-1:0] sum;
  logic                  sat_hi, sat_lo;
  logic [31:0]           res_value;
  logic [1:0]            res_status;

  assign sum    = acc_r + ACW'($signed(bias_r[FAW'(f_r)]));
  assign sat_hi = sum > $signed(ACW'(33'sh0_7FFF_FFFF));
  assign sat_lo = sum < -$signed(ACW'(33'sh0_8000_0000));

  always_comb begin
    if (oom_r) begin
      res_value  = '0;
      res_status = STAT_OOM;
    end else if (sat_hi) begin
      res_value  = 32'h7FFF_FFFF;
      res_status = STAT_SAT;
    end else if (sat_lo) begin
      res_value  = 32'h8000_0000;
      res_status = STAT_SAT;
    end else begin
      res_value  = sum[31:0];
      res_status = STAT_OK;
    end
  end

  // Output register
  logic        out_v_r;
  logic [31:0] out_value_r;
  logic [13:0] out_index_r;
  logic [1:0]  out_status_r;
  logic        out_load;

  assign out_load   = (state_r == ST_OUT) && (!out_v_r || out_tready);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_index_r, out_value_r};
  assign out_tuser  = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r  <= res_value;
      out_index_r  <= oom_r ? 14'd0 : idx_r;
      out_status_r <= res_status;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and handshake
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && (kind == KIND_COMPUTE)) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (done_w && done_h) begin
          if ((SZW'(f_r) >= m_c) || (SZW'(row_r) >= oh_v) || (SZW'(col_r) >= ow_v)) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_S1;
          end
        end
      end
      ST_S1:    state_nxt = ST_S2;
      ST_S2:    state_nxt = ST_S3;
      ST_S3:    state_nxt = ST_RUN;
      ST_RUN: begin
        if (last_tap) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_v_r && !p2_v_r) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (state_r == ST_CLEAR) begin
      clr_cnt_r <= clr_cnt_r + (WAW + 1)'(1);
    end
  end

  // Multiply-accumulate pipeline: memory read, product, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r <= (state_r == ST_RUN);
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_ok_r <= tap_ok;
    prod_r  <= p1_ok_r ? $signed(w_rdata) * $signed(x_rdata) : 32'sd0;
  end

  // Datapath of the compute sequence
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        f_r    <= out_filter;
        row_r  <= out_row;
        col_r  <= out_col;
        rw_r   <= span_w;
        rh_r   <= span_h;
        negw_r <= span_w < 0;
        negh_r <= span_h < 0;
        qw_r   <= '0;
        qh_r   <= '0;
        oom_r  <= 1'b0;
      end
      ST_DIV: begin
        if (!done_w) begin
          rw_r <= rw_r - $signed(SPW'(s_c));
          qw_r <= qw_r + SZW'(1);
        end
        if (!done_h) begin
          rh_r <= rh_r - $signed(SPW'(s_c));
          qh_r <= qh_r + SZW'(1);
        end
        ow_r  <= ow_v;
        oh_r  <= oh_v;
        oom_r <= (SZW'(f_r) >= m_c) || (SZW'(row_r) >= oh_v) || (SZW'(col_r) >= ow_v);
      end
      ST_S1: begin
        kk_r  <= (2 * SZW)'(k_c * k_c);
        foh_r <= 14'(f_r * oh_r);
        y0_r  <= $signed(CW'(row_r * s_c)) - $signed(CW'(p_c));
        x0_r  <= $signed(CW'(col_r * s_c)) - $signed(CW'(p_c));
      end
      ST_S2: begin
        dk_r   <= (3 * SZW)'(d_c * kk_r);
        idx1_r <= foh_r + 14'(row_r);
        hw_r   <= $signed(XW'(h_c * w_c));
        y0w_r  <= XW'(y0_r) * $signed(XW'(w_c));
      end
      ST_S3: begin
        widx_r   <= WAW'(f_r * dk_r);
        idx_r    <= 14'(idx1_r * ow_r) + 14'(col_r);
        c_r      <= '0;
        fy_r     <= '0;
        fx_r     <= '0;
        plane_r  <= '0;
        rowoff_r <= y0w_r;
        y_r      <= y0_r;
        x_r      <= x0_r;
        acc_r    <= '0;
      end
      ST_RUN: begin
        widx_r <= widx_r + WAW'(1);
        if (fx_end) begin
          fx_r <= '0;
          x_r  <= x0_r;
          if (fy_end) begin
            fy_r     <= '0;
            y_r      <= y0_r;
            rowoff_r <= y0w_r;
            c_r      <= c_r + SZW'(1);
            plane_r  <= plane_r + hw_r;
          end else begin
            fy_r     <= fy_r + SZW'(1);
            y_r      <= y_r + CW'(1);
            rowoff_r <= rowoff_r + $signed(XW'(w_c));
          end
        end else begin
          fx_r <= fx_r + SZW'(1);
          x_r  <= x_r + CW'(1);
        end
      end
      default: ;
    endcase
    if (p2_v_r) begin
      acc_r <= acc_r + ACW'(prod_r);
    end
  end

endmodule

FILE: sv/c2d_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2d_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
